// ===== rtl/horizontal_predictor_strip_assert.svh =====
// Assertion macros used by the checker of the horizontal predictor strip.
`ifndef HORIZONTAL_PREDICTOR_STRIP_ASSERT_SVH
`define HORIZONTAL_PREDICTOR_STRIP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hps_pkg.sv =====
`timescale 1ns / 1ps

package hps_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_W      = 2;
    localparam int CHAN_CFG_W  = 4;
    localparam int ROW_W       = 16;
    localparam int BYTE_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_8BIT  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16BIT = 2'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SIZE_W-1:0]     sample_size_code;
        logic                  predictor_on;
        logic                  swap_on;
        logic [CHAN_CFG_W-1:0] channels;
        logic [ROW_W-1:0]      row_width;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic [1:0] count;
        entry_t     first;
        entry_t     second;
    } result_t;

endpackage

// ===== rtl/horizontal_predictor_strip.sv =====
`timescale 1ns / 1ps

// Horizontal differencing predictor and byte-pair swapper for one image strip.
// The block takes one strip byte per cycle and puts out at most one byte per
// cycle. Each accepted byte is worked on in the cycle of its transfer and its
// results go into a four-entry output queue, so the earliest result shows in the
// cycle after the input transfer. The input stalls only while fewer than two
// queue entries are free, which is set by the output side taking results; with
// the output never stalled the block sustains one byte per cycle in every mode.
// In 16-bit swap mode the first byte of a pair gives no result and both
// bytes leave after the second one arrives. The user must write configuration
// through the plain write port only while no strip is in flight; not enforced.
module horizontal_predictor_strip
    import hps_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  out_last
);

    cfg_t    cfg_reg;
    result_t result;
    logic    accept;
    logic    full;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_size_code <= SIZE_8BIT;
            cfg_reg.predictor_on     <= 1'b0;
            cfg_reg.swap_on          <= 1'b0;
            cfg_reg.channels         <= CHAN_CFG_W'(1);
            cfg_reg.row_width        <= ROW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_SIZE: cfg_reg.sample_size_code <= cfg_data[SIZE_W-1:0];
                REG_PREDICTOR:   cfg_reg.predictor_on     <= cfg_data[0];
                REG_SWAP:        cfg_reg.swap_on          <= cfg_data[0];
                REG_CHANNELS:    cfg_reg.channels         <= cfg_data[CHAN_CFG_W-1:0];
                REG_ROW_WIDTH:   cfg_reg.row_width        <= cfg_data[ROW_W-1:0];
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    hps_core #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .data_byte(data_byte),
        .in_last  (in_last),
        .result   (result)
    );

    hps_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .full     (full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

// ===== rtl/hps_core.sv =====
`timescale 1ns / 1ps

module hps_core
    import hps_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              in_last,
    output result_t           result
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CHAN_CFG_W-1:0] MAX_CH_CODE = CHAN_CFG_W'(MAX_CHANNELS);

    logic [BYTE_W-1:0] left_reg [MAX_CHANNELS];
    logic [ROW_W-1:0]  pixel_index_reg, pixel_index_next;
    logic [CH_W-1:0]   channel_index_reg, channel_index_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;

    logic [CHAN_CFG_W-1:0] nch;
    logic [CHAN_CFG_W-1:0] ch_eff;
    logic [CH_W-1:0]       ch_sel;
    logic [ROW_W-1:0]      wid;
    logic                  diff_mode;
    logic                  swap_mode;
    logic                  pixel_done;
    logic [BYTE_W-1:0]     res_byte;

    always_comb
    begin
        if (cfg.channels == '0)
        begin
            nch = CHAN_CFG_W'(1);
        end
        else if (cfg.channels > MAX_CH_CODE)
        begin
            nch = MAX_CH_CODE;
        end
        else
        begin
            nch = cfg.channels;
        end

        if (CHAN_CFG_W'(channel_index_reg) >= nch)
        begin
            ch_eff = nch - CHAN_CFG_W'(1);
        end
        else
        begin
            ch_eff = CHAN_CFG_W'(channel_index_reg);
        end
        ch_sel = ch_eff[CH_W-1:0];

        wid = (cfg.row_width == '0) ? ROW_W'(1) : cfg.row_width;

        diff_mode = (cfg.sample_size_code == SIZE_8BIT) && cfg.predictor_on;
        swap_mode = (cfg.sample_size_code == SIZE_16BIT) && cfg.swap_on;

        if (diff_mode && (pixel_index_reg != '0))
        begin
            res_byte = data_byte - left_reg[ch_sel];
        end
        else
        begin
            res_byte = data_byte;
        end

        pixel_done = ({1'b0, ch_eff} + (CHAN_CFG_W + 1)'(1)) >= {1'b0, nch};

        if (pixel_done)
        begin
            channel_index_next = '0;
            if (({1'b0, pixel_index_reg} + (ROW_W + 1)'(1)) >= {1'b0, wid})
            begin
                pixel_index_next = '0;
            end
            else
            begin
                pixel_index_next = pixel_index_reg + ROW_W'(1);
            end
        end
        else
        begin
            channel_index_next = ch_sel + CH_W'(1);
            pixel_index_next   = pixel_index_reg;
        end

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        result          = '0;

        if (swap_mode)
        begin
            if (held_valid_reg)
            begin
                result.count       = 2'd2;
                result.first.data  = data_byte;
                result.first.last  = 1'b0;
                result.second.data = held_byte_reg;
                result.second.last = in_last;
                held_valid_next    = 1'b0;
                held_byte_next     = '0;
            end
            else if (in_last)
            begin
                result.count      = 2'd1;
                result.first.data = data_byte;
                result.first.last = 1'b1;
            end
            else
            begin
                held_byte_next  = data_byte;
                held_valid_next = 1'b1;
            end
        end
        else
        begin
            if (held_valid_reg)
            begin
                result.count       = 2'd2;
                result.first.data  = held_byte_reg;
                result.first.last  = 1'b0;
                result.second.data = res_byte;
                result.second.last = in_last;
                held_valid_next    = 1'b0;
                held_byte_next     = '0;
            end
            else
            begin
                result.count      = 2'd1;
                result.first.data = res_byte;
                result.first.last = in_last;
            end
        end

        if (in_last)
        begin
            pixel_index_next   = '0;
            channel_index_next = '0;
            held_byte_next     = '0;
            held_valid_next    = 1'b0;
        end

        if (!accept)
        begin
            result.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg   <= '0;
            channel_index_reg <= '0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pixel_index_reg   <= pixel_index_next;
            channel_index_reg <= channel_index_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && diff_mode)
        begin
            left_reg[ch_sel] <= data_byte;
        end
    end

endmodule

// ===== rtl/hps_out_queue.sv =====
`timescale 1ns / 1ps

module hps_out_queue
    import hps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           result,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    localparam logic [QUEUE_CNT_W-1:0] ROOM_LIMIT = QUEUE_CNT_W'(QUEUE_DEPTH - 2);

    entry_t                 store [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] head_reg, head_next;
    logic [QUEUE_PTR_W-1:0] tail_reg, tail_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;
    logic [QUEUE_PTR_W-1:0] tail_plus1;

    assign out_valid  = (count_reg != '0);
    assign out_byte   = store[head_reg].data;
    assign out_last   = store[head_reg].last;
    assign full       = (count_reg > ROOM_LIMIT);
    assign pop        = out_valid && !out_stall;
    assign tail_plus1 = tail_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + QUEUE_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + QUEUE_PTR_W'(result.count);
        count_next = count_reg + QUEUE_CNT_W'(result.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.count != 2'd0)
        begin
            store[tail_reg] <= result.first;
        end
        if (result.count == 2'd2)
        begin
            store[tail_plus1] <= result.second;
        end
    end

endmodule

// ===== rtl/hps_checker.sv =====
`timescale 1ns / 1ps

`include "horizontal_predictor_strip_assert.svh"

module hps_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last
);

    `HPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(out_last), "Stalled output transfer changed.")
    `HPS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid,
        "Stalled input transfer was withdrawn.")
    `HPS_ASSERT_SAME(a_stall_needs_backlog, clk, rst_n, in_stall, out_valid,
        "Input stalled with no result waiting.")
    `HPS_ASSERT_NEXT(a_no_invented, clk, rst_n, !out_valid && !(in_valid && !in_stall),
        !out_valid, "Result appeared without an input transfer.")

endmodule

bind horizontal_predictor_strip hps_checker u_hps_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hps_pkg::*;

    localparam int MAX_CHANNELS = 8;
    localparam int RANDOM_BYTES = 1600;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_OFF = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT = 200;
    localparam logic [SIZE_W-1:0] SIZE_OTHER = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;
    localparam logic [4:0] ALL_REGS = 5'h1F;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [BYTE_W-1:0] data_byte = '0;
    logic in_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic out_last;

    horizontal_predictor_strip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // Model state of the strip position, the left-pixel samples and the pair being swapped.
    cfg_t cur_cfg;
    logic [BYTE_W-1:0] left_smp [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] row_written;
    logic [ROW_W-1:0] pixel_pos;
    logic [2:0] chan_pos;
    logic [BYTE_W-1:0] pair_byte;
    logic pair_held;

    entry_t strip_feed[$];
    entry_t expected_bytes[$];
    entry_t want_byte;
    entry_t feed_item;

    bit offering = 1'b0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int feed_gap = 0;
    int feed_streak = 0;
    int drain_gap = 0;
    int drain_streak = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int diffed_bytes = 0;
    int swapped_pairs = 0;
    int settings_used = 0;
    int midstrip_changes = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic entry_t byte_entry(input logic [BYTE_W-1:0] b, input logic l);
        entry_t e;
        e.data = b;
        e.last = l;
        return e;
    endfunction

    function automatic int eff_channels(input logic [CHAN_CFG_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(c);
    endfunction

    function automatic int eff_width(input logic [ROW_W-1:0] w);
        return (w == 0) ? 1 : int'(w);
    endfunction

    task automatic predict_strip_bytes(input logic [BYTE_W-1:0] b, input logic last);
        int nch;
        int wid;
        int ch;
        logic [BYTE_W-1:0] res;
        nch = eff_channels(cur_cfg.channels);
        wid = eff_width(cur_cfg.row_width);
        ch = (int'(chan_pos) >= nch) ? nch - 1 : int'(chan_pos);
        res = b;
        if (cur_cfg.sample_size_code == SIZE_8BIT && cur_cfg.predictor_on)
        begin
            if (pixel_pos != 0)
            begin
                res = b - left_smp[ch];
                diffed_bytes++;
            end
            left_smp[ch] = b;
            row_written[ch] = 1'b1;
        end
        if (ch + 1 >= nch)
        begin
            chan_pos = '0;
            if (int'(pixel_pos) + 1 >= wid)
            begin
                pixel_pos = '0;
                row_written = '0;
            end
            else
            begin
                pixel_pos = pixel_pos + 16'd1;
            end
        end
        else
        begin
            chan_pos = 3'(ch + 1);
        end
        if (cur_cfg.sample_size_code == SIZE_16BIT && cur_cfg.swap_on)
        begin
            if (pair_held)
            begin
                expected_bytes.push_back(byte_entry(b, 1'b0));
                expected_bytes.push_back(byte_entry(pair_byte, last));
                pair_held = 1'b0;
                swapped_pairs++;
            end
            else if (last)
            begin
                expected_bytes.push_back(byte_entry(b, 1'b1));
            end
            else
            begin
                pair_byte = b;
                pair_held = 1'b1;
            end
        end
        else
        begin
            if (pair_held)
            begin
                expected_bytes.push_back(byte_entry(pair_byte, 1'b0));
                pair_held = 1'b0;
            end
            expected_bytes.push_back(byte_entry(res, last));
        end
        if (last)
        begin
            pixel_pos = '0;
            chan_pos = '0;
            pair_held = 1'b0;
            row_written = '0;
        end
        bytes_in++;
    endtask

    // A setting may change mid-row only if every left sample it will read was written in this row.
    function automatic bit safe_cfg(input cfg_t c);
        int nch;
        int wid;
        int ch;
        if (!(c.sample_size_code == SIZE_8BIT && c.predictor_on))
            return 1'b1;
        nch = eff_channels(c.channels);
        wid = eff_width(c.row_width);
        ch = (int'(chan_pos) >= nch) ? nch - 1 : int'(chan_pos);
        for (int k = 0; k < nch; k++)
        begin
            if (!row_written[k] && ((k < ch && int'(pixel_pos) + 1 < wid) ||
                                    (k >= ch && pixel_pos != 0)))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic cfg_t build_cfg(input logic [SIZE_W-1:0] size, input logic pred,
                                       input logic swap, input logic [CHAN_CFG_W-1:0] ch,
                                       input logic [ROW_W-1:0] width);
        cfg_t c;
        c.sample_size_code = size;
        c.predictor_on = pred;
        c.swap_on = swap;
        c.channels = ch;
        c.row_width = width;
        return c;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            c.sample_size_code = SIZE_8BIT;
        else if (r < 8)
            c.sample_size_code = SIZE_16BIT;
        else
            c.sample_size_code = ($urandom_range(0, 1) == 0) ? SIZE_OTHER : SIZE_SPARE;
        c.predictor_on = ($urandom_range(0, 3) != 0);
        c.swap_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 19);
        if (r < 16)
            c.channels = CHAN_CFG_W'($urandom_range(1, MAX_CHANNELS));
        else if (r == 16)
            c.channels = '0;
        else
            c.channels = CHAN_CFG_W'($urandom_range(MAX_CHANNELS + 1, 15));
        r = $urandom_range(0, 19);
        if (r < 14)
            c.row_width = ROW_W'($urandom_range(1, 6));
        else if (r == 14)
            c.row_width = '0;
        else if (r == 15)
            c.row_width = '1;
        else if (r < 18)
            c.row_width = ROW_W'($urandom_range(7, 40));
        else
            c.row_width = ROW_W'($urandom);
        return c;
    endfunction

    function automatic int pause_len(inout int streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            streak = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_SAMPLE_SIZE: cur_cfg.sample_size_code = value[SIZE_W-1:0];
            REG_PREDICTOR:   cur_cfg.predictor_on = value[0];
            REG_SWAP:        cur_cfg.swap_on = value[0];
            REG_CHANNELS:    cur_cfg.channels = value[CHAN_CFG_W-1:0];
            REG_ROW_WIDTH:   cur_cfg.row_width = value[ROW_W-1:0];
            default:         ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random values.
    task automatic apply_config(input cfg_t c, input logic [4:0] which);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        if (which[REG_SAMPLE_SIZE])
            write_reg(REG_SAMPLE_SIZE, {noise[CFG_DATA_W-1:SIZE_W], c.sample_size_code});
        if (which[REG_PREDICTOR])
            write_reg(REG_PREDICTOR, {noise[CFG_DATA_W-1:1], c.predictor_on});
        if (which[REG_SWAP])
            write_reg(REG_SWAP, {noise[CFG_DATA_W-1:1], c.swap_on});
        if (which[REG_CHANNELS])
            write_reg(REG_CHANNELS, {noise[CFG_DATA_W-1:CHAN_CFG_W], c.channels});
        if (which[REG_ROW_WIDTH])
            write_reg(REG_ROW_WIDTH, c.row_width);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        strip_feed.push_back(byte_entry(b, last));
    endtask

    task automatic settle();
        while (strip_feed.size() != 0 || offering || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (offering && in_taken)
            begin
                offering = 1'b0;
                feed_gap = pause_len(feed_streak);
            end
            in_taken = 1'b0;
            if (!offering)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                end
                else if (strip_feed.size() != 0)
                begin
                    feed_item = strip_feed.pop_front();
                    data_byte <= feed_item.data;
                    in_last <= feed_item.last;
                    offering = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // The receiver holds off for a long stretch twice so the output queue fills up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                drain_gap = pause_len(drain_streak);
                if (results_seen == 300 || results_seen == 1000)
                    hold_left = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (drain_gap > 0)
            begin
                drain_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                out_taken = 1'b1;
                results_seen++;
                quiet_cycles = 0;
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: unexpected transfer, got byte %02h last %0b",
                                 $time, out_byte, out_last);
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (out_byte !== want_byte.data || out_last !== want_byte.last)
                    begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT)
                            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                                     $time, want_byte.data, want_byte.last, out_byte, out_last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                quiet_cycles = 0;
                predict_strip_bytes(data_byte, in_last);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t trial;
        cfg_t fresh;
        logic [4:0] which;
        int queued;
        int strips;
        int len;
        int split;
        int tries;

        cur_cfg = build_cfg(SIZE_8BIT, 1'b0, 1'b0, 4'd1, 16'd1);
        for (int k = 0; k < MAX_CHANNELS; k++)
            left_smp[k] = '0;
        row_written = '0;
        pixel_pos = '0;
        chan_pos = '0;
        pair_byte = '0;
        pair_held = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Differencing with wraparound, two pixels per row.
        apply_config(build_cfg(SIZE_8BIT, 1'b1, 1'b0, 4'd3, 16'd2), ALL_REGS);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b1);
        settle();

        // Swapped pairs with an unpaired final byte; channels and row width out of range.
        apply_config(build_cfg(SIZE_16BIT, 1'b0, 1'b1, 4'd15, 16'd0), ALL_REGS);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hEE, 1'b1);
        settle();

        // Swap turned off while half a pair is held.
        push_byte(8'h55, 1'b0);
        settle();
        apply_config(build_cfg(SIZE_16BIT, 1'b0, 1'b0, 4'd15, 16'd0), 5'b1 << REG_SWAP);
        push_byte(8'h66, 1'b1);
        settle();

        // Channel count cut to zero in the middle of a pixel.
        apply_config(build_cfg(SIZE_8BIT, 1'b1, 1'b0, 4'd4, 16'hFFFF), ALL_REGS);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h12, 1'b0);
        settle();
        apply_config(build_cfg(SIZE_8BIT, 1'b1, 1'b0, 4'd0, 16'hFFFF), 5'b1 << REG_CHANNELS);
        push_byte(8'h21, 1'b1);
        settle();

        apply_config(build_cfg(SIZE_SPARE, 1'b1, 1'b1, 4'd8, 16'd1), ALL_REGS);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);

        queued = 0;
        while (queued < RANDOM_BYTES)
        begin
            settle();
            apply_config(rand_cfg(), ALL_REGS);
            strips = $urandom_range(1, 4);
            for (int s = 0; s < strips; s++)
            begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = 2;
                    default: len = $urandom_range(3, 48);
                endcase
                split = 0;
                if (len > 1 && $urandom_range(0, 4) == 0)
                    split = $urandom_range(1, len - 1);
                for (int i = 0; i < len; i++)
                begin
                    if (split != 0 && i == split)
                    begin
                        settle();
                        for (tries = 0; tries < 8; tries++)
                        begin
                            fresh = rand_cfg();
                            which = 5'($urandom_range(1, 31));
                            trial = cur_cfg;
                            if (which[REG_SAMPLE_SIZE])
                                trial.sample_size_code = fresh.sample_size_code;
                            if (which[REG_PREDICTOR])
                                trial.predictor_on = fresh.predictor_on;
                            if (which[REG_SWAP])
                                trial.swap_on = fresh.swap_on;
                            if (which[REG_CHANNELS])
                                trial.channels = fresh.channels;
                            if (which[REG_ROW_WIDTH])
                                trial.row_width = fresh.row_width;
                            if (safe_cfg(trial))
                                break;
                        end
                        if (tries < 8)
                        begin
                            apply_config(trial, which);
                            midstrip_changes++;
                        end
                    end
                    push_byte(BYTE_W'($urandom), i == len - 1);
                    queued++;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
            mismatches++;
        end
        $display("Run covered %0d strip bytes in and %0d out over %0d register settings,",
                 bytes_in, results_seen, settings_used);
        $display("with %0d differenced bytes, %0d swapped pairs and %0d mid-strip changes.",
                 diffed_bytes, swapped_pairs, midstrip_changes);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hps_pkg.sv
rtl/hps_core.sv
rtl/hps_out_queue.sv
rtl/horizontal_predictor_strip.sv
rtl/hps_checker.sv
test/tb_top.sv
